@@ design/lpht_pkg.sv @@
// Package for the linear-probing hash table: payload types, field widths,
// status and action codes. No dependencies.
package lpht_pkg;

    localparam int KEY_BITS         = 8;
    localparam int VALUE_BITS       = 16;
    localparam int MAX_SLOTS_DEF    = 16;
    localparam int CFG_W            = 5;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 5'd5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] found_value;
    } t_out;

endpackage

@@ design/lpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/lpht_rem.sv @@
// Bit-serial restoring remainder unit: key modulo table size, one key bit a cycle.
// Depends on lpht_pkg.
module lpht_rem
    import lpht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [CFG_W-1:0]    i_div,
    output logic                o_done,
    output logic [CFG_W-1:0]    o_rem
);

    localparam int CNT_W = $clog2(KEY_BITS + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CFG_W-1:0]    r_div, n_div;
    logic [CFG_W-1:0]    r_rem, n_rem;
    logic [CFG_W:0]      w_trial;

    assign w_trial = {r_rem, r_key[KEY_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_key  = r_key;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(KEY_BITS);
            n_key  = i_key;
            n_div  = i_div;
            n_rem  = '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the trial fits CFG_W+1 bits
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = CFG_W'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = CFG_W'(w_trial);
            end
            n_key = r_key << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("done raised while still busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

endmodule

@@ design/linear_probe_hash_table.sv @@
// Top level of the linear-probing key/value table: sequencer, valid bits,
// slot RAM and remainder unit. Depends on lpht_pkg, lpht_ram, lpht_rem.
//
// Channels: input items (insert or lookup) on i_in with valid/ready, one result
// per item on o_out with valid/ready, and a write-only config channel carrying
// table_size (always ready; write only while the table is idle).
// An item is taken only while the sequencer is idle. Per item:
//   the item is registered, key modulo table size is formed in the bit-serial
//   remainder unit, then one slot is probed per cycle (1 up to the
//   active table size) on the RAM's registered read port, then the result
//   moves into the output register once that register is free.
// Items do not overlap: the next item is taken in the cycle after the result
// is registered at the earliest.
// The output register holds a result while the receiver stalls; the next item
// is still accepted and runs until its own result needs the output register.
// Reset clears every valid bit at once and sets table_size to 5; the slot RAM
// is not cleared, since a slot is only read while its valid bit is set.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int ENT_W  = KEY_BITS + VALUE_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CFG_W-1:0]      r_table_size;
    logic [CFG_W-1:0]      r_n, n_n;
    logic [CFG_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [MAX_SLOTS-1:0]  r_valid, n_valid;
    t_in                   r_item, n_item;
    t_out                  r_res, n_res;
    t_out                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_in_xfer;
    logic [CFG_W-1:0]      w_active;
    logic                  w_rem_done;
    logic [CFG_W-1:0]      w_rem;
    logic [ENT_W-1:0]      w_rdata;
    logic [KEY_BITS-1:0]   w_slot_key;
    logic [VALUE_BITS-1:0] w_slot_value;
    logic                  w_slot_valid;
    logic                  w_match;
    logic                  w_we;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // zero acts as one, anything past the slot count as the slot count
    always_comb begin
        if (r_table_size == '0) begin
            w_active = CFG_W'(1);
        end else if (32'(r_table_size) > MAX_SLOTS) begin
            w_active = CFG_W'(MAX_SLOTS);
        end else begin
            w_active = r_table_size;
        end
    end

    lpht_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_key   (i_in.key),
        .i_div   (w_active),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    // read data always belongs to r_idx: the address is the next index
    lpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata ({r_item.key, r_item.value}),
        .i_raddr (n_idx),
        .o_rdata (w_rdata)
    );

    assign w_slot_key   = w_rdata[ENT_W-1:VALUE_BITS];
    assign w_slot_value = w_rdata[VALUE_BITS-1:0];
    assign w_slot_valid = r_valid[r_idx];
    assign w_match      = w_slot_valid && (w_slot_key == r_item.key);
    assign w_we         = (r_state == S_PROBE) && (r_item.action == ACT_INSERT)
                          && (!w_slot_valid || w_match);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_item  = i_in;
                    n_n     = w_active;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    n_idx   = SLOT_W'(w_rem);
                    n_cnt   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!w_slot_valid || w_match) begin
                    if (r_item.action == ACT_INSERT) begin
                        n_valid[r_idx] = 1'b1;
                        n_res.status   = ST_OK;
                        n_res.found_value = '0;
                    end else if (w_match) begin
                        n_res.status      = ST_OK;
                        n_res.found_value = w_slot_value;
                    end else begin
                        n_res.status      = ST_MISS;
                        n_res.found_value = '0;
                    end
                    n_state = S_OUT;
                end else if (r_cnt + 1'b1 == r_n) begin
                    // every slot in use holds some other key
                    n_res.status      = (r_item.action == ACT_INSERT) ? ST_FULL : ST_MISS;
                    n_res.found_value = '0;
                    n_state           = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (32'(r_idx) + 32'd1 == 32'(r_n)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= TABLE_SIZE_RESET;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_cnt        <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            if (i_cfg_valid) begin
                r_table_size <= i_cfg_data;
            end
        end
        r_n    <= n_n;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_cnt < r_n))
        else $error("probe count beyond table size");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (32'(r_idx) < 32'(r_n)))
        else $error("probe index beyond table size");

    a_write_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_PROBE) && (r_item.action == ACT_INSERT))
        else $error("slot write outside an insert probe");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_DIV))
        else $error("accepted item did not start the remainder");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.status == ST_OK) || (r_out.status == ST_MISS)
                         || (r_out.status == ST_FULL)))
        else $error("illegal status code");

endmodule

@@ tb/linear_probe_hash_table_test.sv @@
// Self-checking testbench for linear_probe_hash_table: directed table, then random
// insert/lookup phases under changing table sizes, checked against a local table model.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 100ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_PHASE   = 3;
    localparam int TAIL_CYCLES  = KEY_BITS + MAX_SLOTS_DEF + 6;
    localparam int DIR_ROWS     = 27;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic                  act;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [CFG_W-1:0]      size;
        logic                  typed;
        logic [1:0]            st;
        logic [VALUE_BITS-1:0] fv;
    } dir_row_t;

    // Rows marked typed carry a result that is plain from the spec; the rest go
    // through the table model.
    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_ITEM, ACT_LOOKUP, 8'd0,   16'h0000, 5'd0,  1'b1, ST_MISS, 16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd0,   16'h0000, 5'd0,  1'b1, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd255, 16'hffff, 5'd0,  1'b1, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd255, 16'h0000, 5'd0,  1'b1, ST_OK,   16'hffff},
        '{ROW_ITEM, ACT_LOOKUP, 8'd0,   16'hffff, 5'd0,  1'b1, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd5,   16'h1234, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd10,  16'h5555, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd15,  16'haaaa, 5'd0,  1'b0, ST_OK,   16'h0000},
        // five slots now hold five keys: full table
        '{ROW_ITEM, ACT_INSERT, 8'd20,  16'h0f0f, 5'd0,  1'b1, ST_FULL, 16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd20,  16'h0000, 5'd0,  1'b1, ST_MISS, 16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd255, 16'h8001, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd255, 16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        // size zero behaves as one slot
        '{ROW_CFG,  ACT_INSERT, 8'd0,   16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd0,   16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd7,   16'h7777, 5'd0,  1'b1, ST_FULL, 16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd255, 16'h0000, 5'd0,  1'b1, ST_MISS, 16'h0000},
        // sizes above the slot count clamp to sixteen
        '{ROW_CFG,  ACT_INSERT, 8'd0,   16'h0000, 5'd31, 1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd255, 16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd31,  16'h3131, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd5,   16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_CFG,  ACT_INSERT, 8'd0,   16'h0000, 5'd16, 1'b0, ST_OK,   16'h0000},
        // probe wraps past the top slot
        '{ROW_ITEM, ACT_INSERT, 8'd47,  16'hc3c3, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_CFG,  ACT_INSERT, 8'd0,   16'h0000, 5'd17, 1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd47,  16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_CFG,  ACT_INSERT, 8'd0,   16'h0000, 5'd1,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_LOOKUP, 8'd0,   16'h0000, 5'd0,  1'b0, ST_OK,   16'h0000},
        '{ROW_ITEM, ACT_INSERT, 8'd128, 16'h0001, 5'd0,  1'b0, ST_OK,   16'h0000}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // table model
    logic                  tbl_valid [MAX_SLOTS_DEF];
    logic [KEY_BITS-1:0]   tbl_key   [MAX_SLOTS_DEF];
    logic [VALUE_BITS-1:0] tbl_val   [MAX_SLOTS_DEF];
    logic [CFG_W-1:0]      tbl_size;

    t_out due_results [$];
    int   err_cnt   = 0;
    int   items_in  = 0;
    int   results_n = 0;
    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;
    bit   hold_done = 1'b0;
    int   rx_stall  = 0;

    linear_probe_hash_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Probe and update the table model for one item, returning its result.
    function automatic t_out table_apply(input t_in it);
        int   n;
        int   idx;
        int   visited;
        logic hit;
        t_out res;
        n = (tbl_size == 0) ? 1 : (tbl_size > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(tbl_size);
        idx = int'(it.key) % n;
        hit = 1'b0;
        for (visited = 0; visited < n && !hit; visited++) begin
            if (!tbl_valid[idx] || tbl_key[idx] == it.key)
                hit = 1'b1;
            else
                idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        res.status      = ST_OK;
        res.found_value = '0;
        if (it.action == ACT_INSERT) begin
            if (hit) begin
                tbl_valid[idx] = 1'b1;
                tbl_key[idx]   = it.key;
                tbl_val[idx]   = it.value;
            end else begin
                res.status = ST_FULL;
            end
        end else if (hit && tbl_valid[idx]) begin
            res.found_value = tbl_val[idx];
        end else begin
            res.status = ST_MISS;
        end
        return res;
    endfunction

    task automatic send_item(input t_in it, input logic typed, input t_out typed_res);
        t_out res;
        int   g;
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        res = table_apply(it);
        if (typed) res = typed_res;
        due_results.push_back(res);
        items_in++;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every result, then let the pipeline go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] sz);
        i_cfg_data  <= sz;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_size = sz;
    endtask

    // Result side: check each transfer, then choose how long to hold ready low.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_error($sformatf("result %0d with nothing outstanding", results_n));
                end else begin
                    want = due_results.pop_front();
                    if (o_out.status !== want.status)
                        flag_error($sformatf("result %0d status %0d, want %0d",
                                             results_n, o_out.status, want.status));
                    if (o_out.found_value !== want.found_value)
                        flag_error($sformatf("result %0d found_value %h, want %h",
                                             results_n, o_out.found_value, want.found_value));
                end
                results_n++;
                rx_stall = pick_gap();
            end
            if (hold_req && !hold_done) begin
                rx_stall  = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_in             it;
        t_out            want;
        logic [KEY_BITS-1:0] pool [16];
        int              npool;
        int              plen;
        int              phase;
        int              rnd_sent;
        int              r;
        int              s;
        logic [CFG_W-1:0] sz;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        tbl_size    = TABLE_SIZE_RESET;
        for (int k = 0; k < MAX_SLOTS_DEF; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_key[k]   = '0;
            tbl_val[k]   = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            if (dir_tab[row].kind == ROW_CFG) begin
                settle();
                write_size(dir_tab[row].size);
            end else begin
                it.action        = dir_tab[row].act;
                it.key           = dir_tab[row].key;
                it.value         = dir_tab[row].val;
                want.status      = dir_tab[row].st;
                want.found_value = dir_tab[row].fv;
                send_item(it, dir_tab[row].typed, want);
            end
        end

        phase    = 0;
        rnd_sent = 0;
        while (rnd_sent < RANDOM_ITEMS) begin
            settle();
            r = $urandom_range(0, 9);
            if (r == 0)
                sz = 5'd0;
            else if (r == 1)
                sz = 5'd31;
            else if (r == 2)
                sz = 5'($urandom_range(17, 30));
            else
                sz = 5'($urandom_range(1, 16));
            write_size(sz);
            quiet <= (phase != HOLD_PHASE) && ($urandom_range(0, 4) == 0);

            // mix keys already held with fresh ones so lookups hit and inserts overwrite
            npool = $urandom_range(2, 16);
            for (int k = 0; k < npool; k++) begin
                s = $urandom_range(0, MAX_SLOTS_DEF - 1);
                if ($urandom_range(0, 1) == 1 && tbl_valid[s])
                    pool[k] = tbl_key[s];
                else
                    pool[k] = 8'($urandom_range(0, 255));
            end

            plen = (phase == HOLD_PHASE) ? 80 : $urandom_range(30, 100);
            if (phase == HOLD_PHASE) hold_req <= 1'b1;
            for (int j = 0; j < plen; j++) begin
                it.action = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 80)
                    it.key = pool[$urandom_range(0, npool - 1)];
                else
                    it.key = 8'($urandom_range(0, 255));
                it.value = 16'($urandom);
                send_item(it, 1'b0, '0);
                rnd_sent++;
            end
            phase++;
        end

        settle();
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
